### design/modbus_response_deframer_top_assert.svh
// Assertion macros for the deframer checker
`ifndef MODBUS_RESPONSE_DEFRAMER_TOP_ASSERT_SVH
`define MODBUS_RESPONSE_DEFRAMER_TOP_ASSERT_SVH

// Clocked check, masked while reset is asserted
`define MRD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds across reset
`define MRD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/mrd_pkg.sv
// Shared types, codes and the CRC-16/Modbus byte update for the deframer
package mrd_pkg;

  // Input kind codes
  localparam logic [1:0] KIND_ARM  = 2'd0;
  localparam logic [1:0] KIND_BYTE = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;
  localparam logic [1:0] KIND_RSVD = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CRC     = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_HEADER  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_STATION  = 2'd0;
  localparam logic [1:0] REG_FUNCTION = 2'd1;
  localparam logic [1:0] REG_TIMEOUT  = 2'd2;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  BYTE_COUNT = 8'h04;

  // Queued work item: classified kind plus the received byte
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } mrd_item_t;

  // Live configuration seen by the back end
  typedef struct packed {
    logic [7:0]  station;
    logic [7:0]  function_code;
    logic [15:0] timeout;
  } mrd_cfg_t;

  // Advance the reflected CRC by one byte, one bit per step
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### design/mrd_front.sv
// Front end: accept items, drop reserved kinds, queue the rest in a two-entry FIFO
module mrd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] data_byte
  input  logic [1:0]        in_tuser,   // [1:0] kind
  output logic              head_valid,
  output mrd_pkg::mrd_item_t head_item,
  input  logic              head_pop
);
  import mrd_pkg::*;

  mrd_item_t  q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       accept;
  logic       push;
  logic       pop;

  // Classify: reserved kind is accepted and dropped here
  assign in_tready = (count_r != 2'd2);
  assign accept    = in_tvalid && in_tready;
  assign push      = accept && (in_tuser != KIND_RSVD);
  assign pop       = head_pop && head_valid;

  assign head_valid = (count_r != 2'd0);
  assign head_item  = q_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the queued payload
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{op: in_tuser, data: in_tdata};
    end
  end

endmodule

### design/mrd_back.sv
// Back end: frame state machine, CRC check, timeout and the output register
module mrd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mrd_pkg::mrd_cfg_t cfg,
  input  logic              head_valid,
  input  mrd_pkg::mrd_item_t head_item,
  output logic              head_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,  // [31:0] reading
  output logic [1:0]        out_tuser   // [1:0] status
);
  import mrd_pkg::*;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_ADDR  = 3'd1;
  localparam logic [2:0] PH_FUNC  = 3'd2;
  localparam logic [2:0] PH_COUNT = 3'd3;
  localparam logic [2:0] PH_TAIL  = 3'd4;

  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [31:0] value_r, value_nxt;
  logic [2:0]  tail_r, tail_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_value_r, out_value_nxt;
  logic [1:0]  out_status_r, out_status_nxt;

  logic        slot_free;
  logic        res_valid;
  logic [1:0]  res_status;
  logic [31:0] res_value;
  logic [7:0]  want;
  logic [16:0] tick_next;
  logic [15:0] crc_fed;

  // Take the queue head whenever the output slot is free or draining
  assign slot_free = !out_valid_r || out_tready;
  assign head_pop  = head_valid && slot_free;

  assign want = (phase_r == PH_ADDR) ? cfg.station :
                (phase_r == PH_FUNC) ? cfg.function_code : BYTE_COUNT;
  assign tick_next = {1'b0, ticks_r} + 17'd1;
  assign crc_fed   = crc16_byte(crc_r, head_item.data);

  // Frame sequencing
  always_comb begin
    phase_nxt  = phase_r;
    crc_nxt    = crc_r;
    value_nxt  = value_r;
    tail_nxt   = tail_r;
    crc_lo_nxt = crc_lo_r;
    ticks_nxt  = ticks_r;
    res_valid  = 1'b0;
    res_status = ST_OK;
    res_value  = 32'd0;
    if (head_pop) begin
      case (head_item.op)
        KIND_ARM: begin
          phase_nxt  = PH_ADDR;
          crc_nxt    = CRC_INIT;
          value_nxt  = 32'd0;
          tail_nxt   = 3'd0;
          crc_lo_nxt = 8'd0;
          ticks_nxt  = 16'd0;
        end
        KIND_TICK: begin
          if (phase_r != PH_IDLE) begin
            if (tick_next > {1'b0, cfg.timeout}) begin
              res_valid  = 1'b1;
              res_status = ST_TIMEOUT;
              phase_nxt  = PH_IDLE;
            end else begin
              ticks_nxt = tick_next[15:0];
            end
          end
        end
        KIND_BYTE: begin
          case (phase_r)
            PH_ADDR, PH_FUNC, PH_COUNT: begin
              if (head_item.data != want) begin
                res_valid  = 1'b1;
                res_status = ST_HEADER;
                phase_nxt  = PH_IDLE;
              end else begin
                crc_nxt   = crc_fed;
                ticks_nxt = 16'd0;
                phase_nxt = phase_r + 3'd1;
              end
            end
            PH_TAIL: begin
              if (tail_r < 3'd4) begin
                crc_nxt   = crc_fed;
                value_nxt = {value_r[23:0], head_item.data};
                tail_nxt  = tail_r + 3'd1;
              end else if (tail_r == 3'd4) begin
                crc_lo_nxt = head_item.data;
                tail_nxt   = 3'd5;
              end else begin
                tail_nxt  = 3'd0;
                res_valid = 1'b1;
                phase_nxt = PH_IDLE;
                if (crc_lo_r == crc_r[7:0] && head_item.data == crc_r[15:8]) begin
                  res_status = ST_OK;
                  res_value  = value_r;
                end else begin
                  res_status = ST_CRC;
                end
              end
            end
            default: begin
              // idle: drop the byte
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // Load or drain the output register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    if (slot_free) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_value_nxt  = res_value;
        out_status_nxt = res_status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      crc_r       <= CRC_INIT;
      value_r     <= 32'd0;
      tail_r      <= 3'd0;
      crc_lo_r    <= 8'd0;
      ticks_r     <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      crc_r       <= crc_nxt;
      value_r     <= value_nxt;
      tail_r      <= tail_nxt;
      crc_lo_r    <= crc_lo_nxt;
      ticks_r     <= ticks_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

endmodule

### design/modbus_response_deframer_top.sv
// Modbus RTU read-response deframer: top level with configuration registers
// Throughput: one item per cycle while the output slot is free; the CRC byte update and
// frame step are combinational. A result reaches out_tvalid through the queue entry and then
// the output register, into which the frame state machine steps the queue head.
// Reset (rst_n low, synchronous): queue empties, frame goes idle, no result pending,
// registers return to station 1, function 3, timeout 500 ticks.
module modbus_response_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] reading
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import mrd_pkg::*;

  mrd_cfg_t  cfg_r, cfg_nxt;
  logic      head_valid;
  mrd_item_t head_item;
  logic      head_pop;

  // Write configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_STATION:  cfg_nxt.station       = cfg_wdata[7:0];
        REG_FUNCTION: cfg_nxt.function_code = cfg_wdata[7:0];
        REG_TIMEOUT:  cfg_nxt.timeout       = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{station: 8'd1, function_code: 8'd3, timeout: 16'd500};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mrd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .head_valid (head_valid),
    .head_item  (head_item),
    .head_pop   (head_pop)
  );

  mrd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_item  (head_item),
    .head_pop   (head_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### design/mrd_checker.sv
// Port-level checks for the deframer, bound to the top level
`include "modbus_response_deframer_top_assert.svh"

module mrd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import mrd_pkg::*;

  // Reset leaves no result pending
  `MRD_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_tvalid, "result valid after reset")

  // Failed frames carry a zero value
  `MRD_ASSERT(a_err_zero, (out_tvalid && out_tuser != ST_OK) |-> (out_tdata == 32'd0), "nonzero value on error status")

  // Stalled result stays offered
  `MRD_ASSERT(a_out_hold, (out_tvalid && !out_tready) |=> out_tvalid, "result dropped while stalled")

  // Stalled result keeps its value and status
  `MRD_ASSERT(a_out_stable, (out_tvalid && !out_tready) |=> ($stable(out_tdata) && $stable(out_tuser)), "result changed while stalled")

endmodule

bind modbus_response_deframer_top mrd_checker u_mrd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### sim/tb_modbus_response_deframer_top.sv
// Testbench for the Modbus RTU response deframer: directed frames, random traffic, scoreboard
module tb_modbus_response_deframer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mrd_pkg::*;

  typedef enum logic [2:0] {FR_IDLE, FR_ADDR, FR_FUNC, FR_COUNT, FR_TAIL} frame_phase_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] data_byte
  logic [1:0]  in_tuser = '0;   // [1:0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [31:0] reading
  logic [1:0]  out_tuser;       // [1:0] status
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  // Mirror of the configuration registers
  logic [7:0]   cfg_station;
  logic [7:0]   cfg_function;
  logic [15:0]  cfg_timeout;

  // Mirror of the frame state
  frame_phase_t frame_phase;
  logic [15:0]  crc_acc;
  logic [31:0]  value_acc;
  logic [2:0]   tail_cnt;
  logic [7:0]   crc_low_seen;
  logic [15:0]  tick_cnt;

  reading_t     expected_readings[$];
  int           error_count = 0;
  int           items_sent = 0;
  int           send_gap_pct = 0;
  int           recv_stall_pct = 0;

  modbus_response_deframer_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  // Stall the result side at random
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Reflected CRC-16 with polynomial 0xA001, one byte
  function automatic logic [15:0] crc_modbus_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  task automatic reset_mirror();
    cfg_station  = 8'd1;
    cfg_function = 8'd3;
    cfg_timeout  = 16'd500;
    frame_phase  = FR_IDLE;
    crc_acc      = CRC_INIT;
    value_acc    = '0;
    tail_cnt     = '0;
    crc_low_seen = '0;
    tick_cnt     = '0;
  endtask

  // Close the current wait with one reading
  task automatic end_wait(input logic [1:0] status, input logic [31:0] value);
    expected_readings.push_back('{value: value, status: status});
    frame_phase = FR_IDLE;
  endtask

  // Advance the mirrored deframer by one accepted item
  task automatic predict_deframe(input logic [1:0] kind, input logic [7:0] b);
    logic [16:0] next_ticks;
    logic [7:0]  want;
    case (kind)
      KIND_ARM: begin
        frame_phase  = FR_ADDR;
        crc_acc      = CRC_INIT;
        value_acc    = '0;
        tail_cnt     = '0;
        crc_low_seen = '0;
        tick_cnt     = '0;
      end
      KIND_TICK: begin
        if (frame_phase != FR_IDLE) begin
          next_ticks = {1'b0, tick_cnt} + 17'd1;
          if (next_ticks > {1'b0, cfg_timeout}) end_wait(ST_TIMEOUT, '0);
          else tick_cnt = next_ticks[15:0];
        end
      end
      KIND_BYTE: begin
        if (frame_phase == FR_ADDR || frame_phase == FR_FUNC || frame_phase == FR_COUNT) begin
          want = (frame_phase == FR_ADDR) ? cfg_station :
                 (frame_phase == FR_FUNC) ? cfg_function : BYTE_COUNT;
          if (b != want) begin
            end_wait(ST_HEADER, '0);
          end else begin
            crc_acc     = crc_modbus_step(crc_acc, b);
            tick_cnt    = '0;
            frame_phase = frame_phase_t'(frame_phase + 3'd1);
          end
        end else if (frame_phase == FR_TAIL) begin
          if (tail_cnt < 3'd4) begin
            crc_acc   = crc_modbus_step(crc_acc, b);
            value_acc = {value_acc[23:0], b};
            tail_cnt  = tail_cnt + 3'd1;
          end else if (tail_cnt == 3'd4) begin
            crc_low_seen = b;
            tail_cnt     = 3'd5;
          end else begin
            tail_cnt = '0;
            if (crc_low_seen == crc_acc[7:0] && b == crc_acc[15:8]) end_wait(ST_OK, value_acc);
            else end_wait(ST_CRC, '0);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // Send one item, with an optional gap first, and predict on its transfer
  task automatic send_item(input logic [1:0] kind, input logic [7:0] b);
    @(negedge clk);
    if ($urandom_range(99) < send_gap_pct) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_deframe(kind, b);
    items_sent++;
  endtask

  // Hold the input until every expected reading is out and the pipeline is empty
  task automatic drain_block();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    drain_block();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_STATION:  cfg_station  = value[7:0];
      REG_FUNCTION: cfg_function = value[7:0];
      REG_TIMEOUT:  cfg_timeout  = value;
      default: begin
      end
    endcase
  endtask

  task automatic maybe_ticks(input bit enable);
    if (enable && $urandom_range(99) < 10) begin
      repeat ($urandom_range(3, 1)) send_item(KIND_TICK, 8'($urandom));
    end
  endtask

  // Send one response frame; bad_hdr picks a header byte to corrupt (-1 for none),
  // crc_flip is XORed into the CRC bytes
  task automatic send_frame(input logic [31:0] data, input int bad_hdr,
                            input logic [15:0] crc_flip, input bit with_ticks);
    logic [7:0]  hdr[3];
    logic [15:0] crc;
    logic [7:0]  b;
    hdr = '{cfg_station, cfg_function, BYTE_COUNT};
    crc = CRC_INIT;
    send_item(KIND_ARM, 8'($urandom));
    for (int i = 0; i < 3; i++) begin
      maybe_ticks(with_ticks);
      if (i == bad_hdr) begin
        send_item(KIND_BYTE, hdr[i] ^ 8'($urandom_range(255, 1)));
        return;
      end
      send_item(KIND_BYTE, hdr[i]);
      crc = crc_modbus_step(crc, hdr[i]);
    end
    for (int i = 3; i >= 0; i--) begin
      maybe_ticks(with_ticks);
      b = data[i*8 +: 8];
      send_item(KIND_BYTE, b);
      crc = crc_modbus_step(crc, b);
    end
    crc = crc ^ crc_flip;
    maybe_ticks(with_ticks);
    send_item(KIND_BYTE, crc[7:0]);
    maybe_ticks(with_ticks);
    send_item(KIND_BYTE, crc[15:8]);
  endtask

  // Drop bytes and ticks while idle, ignore the reserved kind
  task automatic test_idle_items();
    send_item(KIND_BYTE, 8'hFF);
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_RSVD, 8'h00);
  endtask

  // Arm while armed restarts at the address; a wrong count byte is a header mismatch
  task automatic test_rearm_and_count();
    send_item(KIND_ARM, 8'h00);
    send_item(KIND_BYTE, cfg_station);
    send_item(KIND_ARM, 8'hFF);
    send_item(KIND_BYTE, cfg_station);
    send_item(KIND_BYTE, cfg_function);
    send_item(KIND_BYTE, 8'h05);
  endtask

  // Well-formed frame with extreme data bytes under reset configuration
  task automatic test_good_frame();
    send_frame(32'hFF00_8001, -1, 16'h0000, 1'b0);
  endtask

  // Zero timeout, then a timeout lowered in the middle of a wait
  task automatic test_timeouts();
    write_reg(REG_TIMEOUT, 16'd0);
    send_item(KIND_ARM, 8'h00);
    send_item(KIND_TICK, 8'h00);
    write_reg(REG_TIMEOUT, 16'd2);
    send_item(KIND_ARM, 8'h00);
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_TICK, 8'h00);
    write_reg(REG_TIMEOUT, 16'd1);
    send_item(KIND_TICK, 8'h00);
  endtask

  task automatic random_config(input bit extremes_a, input bit extremes_b);
    write_reg(REG_STATION, extremes_a ? 16'h0000 : extremes_b ? 16'h00FF : 16'($urandom_range(255)));
    write_reg(REG_FUNCTION, extremes_a ? 16'h00FF : extremes_b ? 16'h0000
                                       : 16'($urandom_range(255)));
    if (extremes_b) write_reg(REG_TIMEOUT, 16'hFFFF);
    else if ($urandom_range(3) == 0) write_reg(REG_TIMEOUT, 16'($urandom));
    else write_reg(REG_TIMEOUT, 16'($urandom_range(6)));
  endtask

  // Mostly well-formed frames with random content, some broken, some noise
  task automatic run_random(input int target, input bit extremes_a, input bit extremes_b);
    int frames;
    int pick;
    frames = 0;
    random_config(extremes_a, extremes_b);
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        send_item(2'($urandom_range(3)), 8'($urandom));
      end else if (pick < 20) begin
        // partial response, then a fresh arm restarts it
        send_item(KIND_ARM, 8'($urandom));
        send_item(KIND_BYTE, cfg_station);
        send_frame($urandom, -1, 16'h0000, 1'b1);
      end else if (pick < 25) begin
        // response cut short; with a timeout under 64, ticks run the wait out
        send_item(KIND_ARM, 8'($urandom));
        send_item(KIND_BYTE, cfg_station);
        send_item(KIND_BYTE, cfg_function);
        if (cfg_timeout < 16'd64) begin
          repeat (cfg_timeout + 1) send_item(KIND_TICK, 8'($urandom));
        end
      end else begin
        send_frame($urandom, ($urandom_range(99) < 8) ? int'($urandom_range(2)) : -1,
                   ($urandom_range(99) < 12) ? 16'($urandom_range(16'hFFFF, 1)) : 16'h0000,
                   1'b1);
      end
      frames++;
      if (frames % 30 == 0) random_config(1'b0, 1'b0);
    end
  endtask

  // Compare each reading with the oldest expectation
  always @(posedge clk) begin : check_reading
    reading_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected reading expected none actual value=%h status=%0d",
                 $time, out_tdata, out_tuser);
        error_count++;
      end else begin
        want = expected_readings.pop_front();
        if (out_tdata !== want.value) begin
          $display("%0t: reading expected %h actual %h", $time, want.value, out_tdata);
          error_count++;
        end
        if (out_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_tuser);
          error_count++;
        end
      end
    end
  end

  initial begin
    reset_mirror();
    send_gap_pct   = 11;
    recv_stall_pct = 47;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_items();
    test_rearm_and_count();
    test_good_frame();
    test_timeouts();
    run_random(420, 1'b1, 1'b0);

    drain_block();
    send_gap_pct   = 47;
    recv_stall_pct = 11;
    run_random(800, 1'b0, 1'b1);

    drain_block();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_random(1150, 1'b0, 1'b0);

    drain_block();
    repeat (10) @(posedge clk);
    if (error_count == 0 && expected_readings.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
